[src/cplps_pkg.sv]
`default_nettype none
package cplps_pkg;

  localparam int COORD_WIDTH    = 32;
  localparam int COUNT_WIDTH    = 5;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int MAX_SUBDIV_DEF = 31;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] vertex_x;
    logic signed [COORD_WIDTH-1:0] vertex_y;
    logic signed [COORD_WIDTH-1:0] vertex_w;
    logic [COUNT_WIDTH-1:0]        subdiv_count;
    logic                          closes_loop;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] proj_u;
    logic signed [COORD_WIDTH-1:0] proj_v;
    logic                          zero_divisor;
    logic                          run_end;
  } out_item_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] ax;
    logic signed [COORD_WIDTH-1:0] ay;
    logic signed [COORD_WIDTH-1:0] aw;
    logic signed [COORD_WIDTH-1:0] bx;
    logic signed [COORD_WIDTH-1:0] by;
    logic signed [COORD_WIDTH-1:0] bw;
    logic [COUNT_WIDTH-1:0]        n;
    logic                          last;
  } seg_cmd_t;

endpackage
`default_nettype wire

[src/closed_polyline_projective_subdivider_top.sv]
// Channel   Ports                          Request moves on
// input     in_push, in_full, in_data      push && !full
// result    out_empty, out_pop, out_data   pop && !empty
// Front stores the loop state and queues up to two segments per vertex (4-entry queue).
// Back per segment: a pop from the queue, then the three parallel delta dividers.
// Back per point: the u/v divide by w, skipped when w is zero; a segment yields n+1
// points, and a closing vertex that follows others causes two segments.
// Reset (rst_n low, synchronous) closes any open loop and empties queue and output.
// A full output register stalls the back; a full queue raises in_full.
`default_nettype none
module closed_polyline_projective_subdivider_top
  import cplps_pkg::*;
#(
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int MAX_SUBDIV = MAX_SUBDIV_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_push,
  output logic          in_full,
  input  wire in_item_t in_data,
  output logic          out_empty,
  input  wire logic     out_pop,
  output out_item_t     out_data
);

  logic     cmd_push, cmd_full, cmd_pop, cmd_empty;
  seg_cmd_t cmd_wdata, cmd_head;

  cplps_front #(.MAX_SUBDIV(MAX_SUBDIV)) u_front (
    .clk, .rst_n, .in_push, .in_data, .in_full,
    .cmd_push, .cmd_data(cmd_wdata), .cmd_full
  );

  cplps_fifo u_fifo (
    .clk, .rst_n, .push(cmd_push), .push_data(cmd_wdata), .full(cmd_full),
    .pop(cmd_pop), .head(cmd_head), .empty(cmd_empty)
  );

  cplps_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk, .rst_n, .cmd(cmd_head), .cmd_empty, .cmd_pop,
    .out_data, .out_empty, .out_pop
  );

endmodule
`default_nettype wire

[src/cplps_udiv.sv]
`default_nettype none
module cplps_udiv #(
  parameter int N = 33,
  parameter int D = 6
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  input  wire logic [N-1:0] dividend,
  input  wire logic [D-1:0] divisor,
  output logic              busy,
  output logic [N-1:0]      quotient
);

  localparam int CNT_W = $clog2(N + 1);

  logic [D-1:0]     rem_r;
  logic [N-1:0]     quo_r;
  logic [D-1:0]     div_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic [D:0]       rem_sh;
  logic [D:0]       rem_sub;
  logic             ge;
  logic [D-1:0]     rem_nxt;

  always_comb begin
    rem_sh  = {rem_r, quo_r[N-1]};
    rem_sub = rem_sh - {1'b0, div_r};
    ge      = rem_sh >= {1'b0, div_r};
    rem_nxt = ge ? rem_sub[D-1:0] : rem_sh[D-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(N);
    end else if (busy_r) begin
      busy_r <= (cnt_r != CNT_W'(1));
      cnt_r  <= cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[N-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

[src/cplps_fifo.sv]
`default_nettype none
module cplps_fifo
  import cplps_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire seg_cmd_t push_data,
  output logic          full,
  input  wire logic     pop,
  output seg_cmd_t      head,
  output logic          empty
);

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);

  seg_cmd_t         mem_r [DEPTH];
  logic [PTR_W-1:0] wr_r;
  logic [PTR_W-1:0] rd_r;
  logic [PTR_W:0]   cnt_r;
  logic             do_push;
  logic             do_pop;

  assign full    = (cnt_r == (PTR_W+1)'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wr_r <= wr_r + PTR_W'(1);
      if (do_pop)  rd_r <= rd_r + PTR_W'(1);
      if (do_push && !do_pop)      cnt_r <= cnt_r + (PTR_W+1)'(1);
      else if (do_pop && !do_push) cnt_r <= cnt_r - (PTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_r] <= push_data;
  end

endmodule
`default_nettype wire

[src/cplps_front.sv]
`default_nettype none
module cplps_front
  import cplps_pkg::*;
#(
  parameter int MAX_SUBDIV = MAX_SUBDIV_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_push,
  input  wire in_item_t in_data,
  output logic          in_full,
  output logic          cmd_push,
  output seg_cmd_t      cmd_data,
  input  wire logic     cmd_full
);

  logic                          have_start_r;
  logic signed [COORD_WIDTH-1:0] start_x_r, start_y_r, start_w_r;
  logic signed [COORD_WIDTH-1:0] prev_x_r, prev_y_r, prev_w_r;
  logic [COUNT_WIDTH-1:0]        prev_n_r;
  seg_cmd_t                      pend_r;
  logic                          pend_valid_r;

  logic                   accept;
  logic [COUNT_WIDTH-1:0] n_cl;
  seg_cmd_t               seg_a;
  seg_cmd_t               seg_b;

  assign in_full = pend_valid_r || cmd_full;
  assign accept  = in_push && !in_full;

  always_comb begin
    n_cl = (in_data.subdiv_count > COUNT_WIDTH'(MAX_SUBDIV)) ?
           COUNT_WIDTH'(MAX_SUBDIV) : in_data.subdiv_count;
    seg_a = '{ax: prev_x_r, ay: prev_y_r, aw: prev_w_r,
              bx: in_data.vertex_x, by: in_data.vertex_y, bw: in_data.vertex_w,
              n: prev_n_r, last: !in_data.closes_loop};
    seg_b = '{ax: in_data.vertex_x, ay: in_data.vertex_y, aw: in_data.vertex_w,
              bx: have_start_r ? start_x_r : in_data.vertex_x,
              by: have_start_r ? start_y_r : in_data.vertex_y,
              bw: have_start_r ? start_w_r : in_data.vertex_w,
              n: n_cl, last: 1'b1};
    cmd_push = 1'b0;
    cmd_data = seg_b;
    if (accept) begin
      cmd_push = have_start_r || in_data.closes_loop;
      cmd_data = have_start_r ? seg_a : seg_b;
    end else if (pend_valid_r) begin
      cmd_push = !cmd_full;
      cmd_data = pend_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_start_r <= 1'b0;
      pend_valid_r <= 1'b0;
      start_x_r    <= '0;
      start_y_r    <= '0;
      start_w_r    <= '0;
      prev_x_r     <= '0;
      prev_y_r     <= '0;
      prev_w_r     <= '0;
      prev_n_r     <= '0;
    end else if (accept) begin
      if (!have_start_r) begin
        start_x_r <= in_data.vertex_x;
        start_y_r <= in_data.vertex_y;
        start_w_r <= in_data.vertex_w;
      end
      have_start_r <= !in_data.closes_loop;
      prev_x_r     <= in_data.vertex_x;
      prev_y_r     <= in_data.vertex_y;
      prev_w_r     <= in_data.vertex_w;
      prev_n_r     <= n_cl;
      pend_valid_r <= have_start_r && in_data.closes_loop;
    end else if (pend_valid_r && !cmd_full) begin
      pend_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) pend_r <= seg_b;
  end

endmodule
`default_nettype wire

[src/cplps_back.sv]
`default_nettype none
module cplps_back
  import cplps_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire seg_cmd_t cmd,
  input  wire logic     cmd_empty,
  output logic          cmd_pop,
  output out_item_t     out_data,
  output logic          out_empty,
  input  wire logic     out_pop
);

  localparam int CW = COORD_WIDTH;
  localparam int DN = CW + 1;
  localparam int DD = COUNT_WIDTH + 1;
  localparam int PN = CW + FRAC_BITS;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DWAIT  = 3'd1;
  localparam logic [2:0] S_PSTART = 3'd2;
  localparam logic [2:0] S_PWAIT  = 3'd3;
  localparam logic [2:0] S_PUT    = 3'd4;

  localparam logic signed [CW-1:0] SAT_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] SAT_MIN = {1'b1, {(CW-1){1'b0}}};

  logic [2:0]             state_r;
  logic [COUNT_WIDTH-1:0] k_r, n_r;
  logic                   last_r;
  logic signed [CW:0]     px_r, py_r, pw_r;
  logic signed [CW:0]     dx_r, dy_r, dw_r;
  logic                   nx_r, ny_r, nw_r;
  logic                   nu_r, nv_r;
  out_item_t              res_r;
  out_item_t              out_r;
  logic                   out_valid_r;

  logic signed [CW:0]  dfx, dfy, dfw;
  logic [DN-1:0]       mx, my, mw;
  logic [DD-1:0]       dsor;
  logic                dstart;
  logic [DN-1:0]       qx, qy, qw;
  logic                bx, by, bw;
  logic [CW-1:0]       ux, uy, uw;
  logic                pstart;
  logic [PN-1:0]       qu, qv;
  logic                bu, bv;
  logic                sat_u, sat_v;
  logic signed [CW-1:0] ru, rv;
  logic                load_out;

  always_comb begin
    dfx = $signed({cmd.bx[CW-1], cmd.bx}) - $signed({cmd.ax[CW-1], cmd.ax});
    dfy = $signed({cmd.by[CW-1], cmd.by}) - $signed({cmd.ay[CW-1], cmd.ay});
    dfw = $signed({cmd.bw[CW-1], cmd.bw}) - $signed({cmd.aw[CW-1], cmd.aw});
    mx  = dfx[CW] ? DN'(-dfx) : DN'(dfx);
    my  = dfy[CW] ? DN'(-dfy) : DN'(dfy);
    mw  = dfw[CW] ? DN'(-dfw) : DN'(dfw);
    dsor = {1'b0, cmd.n} + DD'(1);
    ux  = px_r[CW-1] ? CW'(-px_r[CW-1:0]) : px_r[CW-1:0];
    uy  = py_r[CW-1] ? CW'(-py_r[CW-1:0]) : py_r[CW-1:0];
    uw  = pw_r[CW-1] ? CW'(-pw_r[CW-1:0]) : pw_r[CW-1:0];
    sat_u = |qu[PN-1:CW-1];
    sat_v = |qv[PN-1:CW-1];
    ru = nu_r ? (sat_u ? SAT_MIN : $signed(CW'(-qu[CW-1:0])))
              : (sat_u ? SAT_MAX : $signed(qu[CW-1:0]));
    rv = nv_r ? (sat_v ? SAT_MIN : $signed(CW'(-qv[CW-1:0])))
              : (sat_v ? SAT_MAX : $signed(qv[CW-1:0]));
  end

  assign cmd_pop  = (state_r == S_IDLE) && !cmd_empty;
  assign dstart   = cmd_pop;
  assign pstart   = (state_r == S_PSTART) && (pw_r[CW-1:0] != '0);
  assign load_out = (state_r == S_PUT) && (!out_valid_r || out_pop);

  cplps_udiv #(.N(DN), .D(DD)) u_dx (.clk, .rst_n, .start(dstart), .dividend(mx),
    .divisor(dsor), .busy(bx), .quotient(qx));
  cplps_udiv #(.N(DN), .D(DD)) u_dy (.clk, .rst_n, .start(dstart), .dividend(my),
    .divisor(dsor), .busy(by), .quotient(qy));
  cplps_udiv #(.N(DN), .D(DD)) u_dw (.clk, .rst_n, .start(dstart), .dividend(mw),
    .divisor(dsor), .busy(bw), .quotient(qw));
  cplps_udiv #(.N(PN), .D(CW)) u_pu (.clk, .rst_n, .start(pstart),
    .dividend({ux, {FRAC_BITS{1'b0}}}), .divisor(uw), .busy(bu), .quotient(qu));
  cplps_udiv #(.N(PN), .D(CW)) u_pv (.clk, .rst_n, .start(pstart),
    .dividend({uy, {FRAC_BITS{1'b0}}}), .divisor(uw), .busy(bv), .quotient(qv));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      k_r         <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (!cmd_empty) begin
            state_r <= S_DWAIT;
            k_r     <= '0;
          end
        end
        S_DWAIT: begin
          if (!bx && !by && !bw) state_r <= S_PSTART;
        end
        S_PSTART: begin
          state_r <= pstart ? S_PWAIT : S_PUT;
        end
        S_PWAIT: begin
          if (!bu && !bv) state_r <= S_PUT;
        end
        S_PUT: begin
          if (load_out) begin
            if (k_r == n_r) begin
              state_r <= S_IDLE;
            end else begin
              k_r     <= k_r + COUNT_WIDTH'(1);
              state_r <= S_PSTART;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
      if (load_out)     out_valid_r <= 1'b1;
      else if (out_pop) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      px_r   <= $signed({cmd.ax[CW-1], cmd.ax});
      py_r   <= $signed({cmd.ay[CW-1], cmd.ay});
      pw_r   <= $signed({cmd.aw[CW-1], cmd.aw});
      nx_r   <= dfx[CW];
      ny_r   <= dfy[CW];
      nw_r   <= dfw[CW];
      n_r    <= cmd.n;
      last_r <= cmd.last;
    end
    if (state_r == S_DWAIT) begin
      dx_r <= nx_r ? $signed(-qx) : $signed(qx);
      dy_r <= ny_r ? $signed(-qy) : $signed(qy);
      dw_r <= nw_r ? $signed(-qw) : $signed(qw);
    end
    if (state_r == S_PSTART) begin
      nu_r <= px_r[CW-1] ^ pw_r[CW-1];
      nv_r <= py_r[CW-1] ^ pw_r[CW-1];
      res_r <= '{proj_u: '0, proj_v: '0, zero_divisor: 1'b1, run_end: 1'b0};
    end
    if (state_r == S_PWAIT) begin
      res_r <= '{proj_u: ru, proj_v: rv, zero_divisor: 1'b0, run_end: 1'b0};
    end
    if (load_out) begin
      out_r <= '{proj_u: res_r.proj_u, proj_v: res_r.proj_v,
                 zero_divisor: res_r.zero_divisor,
                 run_end: last_r && (k_r == n_r)};
      px_r <= px_r + dx_r;
      py_r <= py_r + dy_r;
      pw_r <= pw_r + dw_r;
    end
  end

  assign out_data  = out_r;
  assign out_empty = !out_valid_r;

  a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.zero_divisor) |-> (out_r.proj_u == '0 && out_r.proj_v == '0))
    else $error("zero divisor point carries nonzero projection");

  a_k_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> (k_r <= n_r))
    else $error("point index beyond segment count");

  a_put_loads: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> out_valid_r)
    else $error("result lost at output register");

  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PSTART) |-> (!bu && !bv))
    else $error("point divider restarted while busy");

endmodule
`default_nettype wire
